### hw/rtl/bsfr_pkg.sv
package bsfr_pkg;

  // Config register file: eight byte-wide registers at word addresses.
  localparam int unsigned CFG_NREG = 8;
  localparam int unsigned CFG_IW   = $clog2(CFG_NREG);
  localparam int unsigned CFG_AW   = CFG_IW + 2;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [CFG_IW-1:0] REG_FLAG     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ADDR     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INFO0    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INFO1    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_DISC     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ESC      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_ESC_FLAG = 3'd6;
  localparam logic [CFG_IW-1:0] REG_ESC_ESC  = 3'd7;

  localparam logic [7:0] FLAG_RST     = 8'd126;
  localparam logic [7:0] ADDR_RST     = 8'd3;
  localparam logic [7:0] INFO0_RST    = 8'd0;
  localparam logic [7:0] INFO1_RST    = 8'd64;
  localparam logic [7:0] DISC_RST     = 8'd11;
  localparam logic [7:0] ESC_RST      = 8'd125;
  localparam logic [7:0] ESC_FLAG_RST = 8'd94;
  localparam logic [7:0] ESC_ESC_RST  = 8'd93;

  // result_kind codes
  localparam logic [2:0] RK_PAYLOAD = 3'd0;
  localparam logic [2:0] RK_ACCEPT  = 3'd1;
  localparam logic [2:0] RK_REJECT  = 3'd2;
  localparam logic [2:0] RK_DUP     = 3'd3;
  localparam logic [2:0] RK_DISC    = 3'd4;

  // reply_kind codes
  localparam logic [1:0] RP_NONE = 2'd0;
  localparam logic [1:0] RP_RR   = 2'd1;
  localparam logic [1:0] RP_REJ  = 2'd2;

  typedef struct packed {
    logic [7:0] flag;
    logic [7:0] addr;
    logic [7:0] info0;
    logic [7:0] info1;
    logic [7:0] disc;
    logic [7:0] esc;
    logic [7:0] flag_code;
    logic [7:0] esc_esc;
  } cfg_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] payload_byte;
    logic [1:0] reply_kind;
    logic       reply_seq;
    logic       frame_seq;
  } res_t;

  // Output queue status toward the top level.
  typedef struct packed {
    logic valid;
    logic full;
  } oq_stat_t;

endpackage

### hw/rtl/bsfr_in_if.sv
interface bsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/bsfr_out_if.sv
interface bsfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] payload_byte;
  logic [1:0] reply_kind;
  logic       reply_seq;
  logic       frame_seq;

  modport source (output valid, output result_kind, output payload_byte,
                  output reply_kind, output reply_seq, output frame_seq,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input reply_kind, input reply_seq, input frame_seq,
                  output ready);
endinterface

### hw/rtl/bsfr_cfg_regs.sv
module bsfr_cfg_regs import bsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t              cfg_r;
  logic              wr_en;
  logic [CFG_IW-1:0] idx;
  logic [7:0]        rd_byte;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{flag: FLAG_RST, addr: ADDR_RST, info0: INFO0_RST,
                 info1: INFO1_RST, disc: DISC_RST, esc: ESC_RST,
                 flag_code: ESC_FLAG_RST, esc_esc: ESC_ESC_RST};
    end else if (wr_en) begin
      case (idx)
        REG_FLAG:     cfg_r.flag      <= pwdata[7:0];
        REG_ADDR:     cfg_r.addr      <= pwdata[7:0];
        REG_INFO0:    cfg_r.info0     <= pwdata[7:0];
        REG_INFO1:    cfg_r.info1     <= pwdata[7:0];
        REG_DISC:     cfg_r.disc      <= pwdata[7:0];
        REG_ESC:      cfg_r.esc       <= pwdata[7:0];
        REG_ESC_FLAG: cfg_r.flag_code <= pwdata[7:0];
        REG_ESC_ESC:  cfg_r.esc_esc   <= pwdata[7:0];
        default:      cfg_r           <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FLAG:     rd_byte = cfg_r.flag;
      REG_ADDR:     rd_byte = cfg_r.addr;
      REG_INFO0:    rd_byte = cfg_r.info0;
      REG_INFO1:    rd_byte = cfg_r.info1;
      REG_DISC:     rd_byte = cfg_r.disc;
      REG_ESC:      rd_byte = cfg_r.esc;
      REG_ESC_FLAG: rd_byte = cfg_r.flag_code;
      REG_ESC_ESC:  rd_byte = cfg_r.esc_esc;
      default:      rd_byte = '0;
    endcase
  end

  assign prdata = {{(CFG_DW-8){1'b0}}, rd_byte};
  assign cfg    = cfg_r;

endmodule

### hw/rtl/bsfr_parser.sv
module bsfr_parser import bsfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       acc,      // byte transfer this cycle
  input  logic [7:0] rx_byte,
  output logic       res_vld,
  output res_t       res
);

  typedef enum logic [6:0] {
    PH_HUNT      = 7'b0000001,
    PH_ADDR      = 7'b0000010,
    PH_CTRL      = 7'b0000100,
    PH_HCHK_INFO = 7'b0001000,
    PH_HCHK_DISC = 7'b0010000,
    PH_DATA      = 7'b0100000,
    PH_DISC_END  = 7'b1000000
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       exp_seq_r, exp_seq_nxt;
  logic       cur_seq_r, cur_seq_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       esc_pend_r, esc_pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_vld_r, held_vld_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       esc_err_r, esc_err_nxt;
  logic       seen_r, seen_nxt;

  logic [7:0] d;
  logic       d_vld;
  logic       good;

  assign good = !esc_err_r && !esc_pend_r && held_vld_r && seen_r && (xor_r == held_r);

  always_comb begin
    phase_nxt    = phase_r;
    exp_seq_nxt  = exp_seq_r;
    cur_seq_nxt  = cur_seq_r;
    ctrl_nxt     = ctrl_r;
    esc_pend_nxt = esc_pend_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    xor_nxt      = xor_r;
    esc_err_nxt  = esc_err_r;
    seen_nxt     = seen_r;
    d            = rx_byte;
    d_vld        = 1'b0;
    res_vld      = 1'b0;
    res          = '0;

    case (phase_r)
      PH_ADDR: begin
        if (rx_byte == cfg.addr) phase_nxt = PH_CTRL;
        else if (rx_byte != cfg.flag) phase_nxt = PH_HUNT;
      end
      PH_CTRL: begin
        if (rx_byte == cfg.info0) begin
          cur_seq_nxt = 1'b0;
          ctrl_nxt    = rx_byte;
          phase_nxt   = PH_HCHK_INFO;
        end else if (rx_byte == cfg.info1) begin
          cur_seq_nxt = 1'b1;
          ctrl_nxt    = rx_byte;
          phase_nxt   = PH_HCHK_INFO;
        end else if (rx_byte == cfg.disc) begin
          ctrl_nxt  = rx_byte;
          phase_nxt = PH_HCHK_DISC;
        end else if (rx_byte == cfg.flag) begin
          phase_nxt = PH_ADDR;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HCHK_INFO: begin
        if (rx_byte == (cfg.addr ^ ctrl_r)) begin
          phase_nxt    = PH_DATA;
          esc_pend_nxt = 1'b0;
          held_vld_nxt = 1'b0;
          held_nxt     = '0;
          xor_nxt      = '0;
          esc_err_nxt  = 1'b0;
          seen_nxt     = 1'b0;
        end else if (rx_byte == cfg.flag) begin
          phase_nxt = PH_ADDR;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HCHK_DISC: begin
        if (rx_byte == (cfg.addr ^ ctrl_r)) phase_nxt = PH_DISC_END;
        else if (rx_byte == cfg.flag) phase_nxt = PH_ADDR;
        else phase_nxt = PH_HUNT;
      end
      PH_DISC_END: begin
        if (rx_byte == cfg.flag) begin
          phase_nxt       = PH_ADDR;
          res_vld         = 1'b1;
          res.result_kind = RK_DISC;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx_byte == cfg.flag) begin
          // closing flag: verdict, flag doubles as next opening flag
          phase_nxt     = PH_ADDR;
          res_vld       = 1'b1;
          res.reply_seq = ~cur_seq_r;
          res.frame_seq = cur_seq_r;
          if (!good) begin
            res.result_kind = RK_REJECT;
            res.reply_kind  = RP_REJ;
          end else if (cur_seq_r == exp_seq_r) begin
            exp_seq_nxt     = ~exp_seq_r;
            res.result_kind = RK_ACCEPT;
            res.reply_kind  = RP_RR;
          end else begin
            res.result_kind = RK_DUP;
            res.reply_kind  = RP_RR;
          end
        end else if (!esc_err_r) begin
          if (esc_pend_r) begin
            esc_pend_nxt = 1'b0;
            if (rx_byte == cfg.flag_code) begin
              d     = cfg.flag;
              d_vld = 1'b1;
            end else if (rx_byte == cfg.esc_esc) begin
              d     = cfg.esc;
              d_vld = 1'b1;
            end else begin
              esc_err_nxt = 1'b1;
            end
          end else if (rx_byte == cfg.esc) begin
            esc_pend_nxt = 1'b1;
          end else begin
            d_vld = 1'b1;
          end
          // one-byte hold-back: the last byte is the check byte
          if (d_vld) begin
            held_nxt     = d;
            held_vld_nxt = 1'b1;
            if (held_vld_r) begin
              xor_nxt          = xor_r ^ held_r;
              seen_nxt         = 1'b1;
              res_vld          = 1'b1;
              res.result_kind  = RK_PAYLOAD;
              res.payload_byte = held_r;
            end
          end
        end
      end
      default: begin
        if (rx_byte == cfg.flag) phase_nxt = PH_ADDR;
        else phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      exp_seq_r  <= 1'b0;
      cur_seq_r  <= 1'b0;
      ctrl_r     <= '0;
      esc_pend_r <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      xor_r      <= '0;
      esc_err_r  <= 1'b0;
      seen_r     <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      exp_seq_r  <= exp_seq_nxt;
      cur_seq_r  <= cur_seq_nxt;
      ctrl_r     <= ctrl_nxt;
      esc_pend_r <= esc_pend_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      xor_r      <= xor_nxt;
      esc_err_r  <= esc_err_nxt;
      seen_r     <= seen_nxt;
    end
  end

endmodule

### hw/rtl/bsfr_out_queue.sv
module bsfr_out_queue import bsfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  res_t     push_data,
  input  logic     pop_rdy,
  output oq_stat_t stat,
  output res_t     head
);

  // Two-entry result queue; keeps input ready independent of out.ready.
  res_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign stat.valid = (cnt_r != 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign pop        = stat.valid && pop_rdy;
  assign head       = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### hw/rtl/byte_stuffed_frame_receiver.sv
// Byte-stuffed stop-and-wait frame receiver.
// in_ch  : one received line byte per transfer (valid/ready).
// out_ch : zero or one result per byte: a destuffed payload byte, or a
//          frame verdict (accept / reject / duplicate, each with the RR
//          or REJ reply to send and its sequence bit, or disconnect).
// APB    : eight byte registers at 4*i (flag, address, three control
//          codes, escape and the two escaped codes); write only while idle.
// Each result is registered in the output queue on its byte's transfer.
// Payload bytes trail the line by one destuffed byte, since the last byte
// of a frame is its XOR check and is never forwarded.
// Throughput: one byte per cycle unless the queue is full; the parser
// state updates on each transfer, verdict logic is a single compare level.
// Results go to a two-entry queue, so in_ch stays ready while one result
// waits; in_ch.ready drops only with two results waiting on out_ch.
// Reset (synchronous, rst_n low): registers take their defaults, the
// parser hunts for a flag, expected sequence is 0 and the queue empties.
module byte_stuffed_frame_receiver import bsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bsfr_in_if.sink           in_ch,
  bsfr_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  logic     acc;
  logic     res_vld;
  res_t     res;
  res_t     head;
  oq_stat_t oq_stat;

  assign pready = 1'b1;

  bsfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // byte transfer: queue has a free slot
  assign in_ch.ready = !oq_stat.full;
  assign acc         = in_ch.valid && in_ch.ready;

  bsfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .acc     (acc),
    .rx_byte (in_ch.rx_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  bsfr_out_queue u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_vld),
    .push_data (res),
    .pop_rdy   (out_ch.ready),
    .stat      (oq_stat),
    .head      (head)
  );

  assign out_ch.valid        = oq_stat.valid;
  assign out_ch.result_kind  = head.result_kind;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.reply_kind   = head.reply_kind;
  assign out_ch.reply_seq    = head.reply_seq;
  assign out_ch.frame_seq    = head.frame_seq;

  // Queue empty right after reset.
  a_rst_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result pending right after reset");

  // Input stalls only while results wait on the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty result queue");

  // Payload bytes and disconnects carry no reply and no frame sequence.
  a_payload_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.result_kind == RK_PAYLOAD || out_ch.result_kind == RK_DISC)
    |-> out_ch.reply_kind == RP_NONE && !out_ch.frame_seq && !out_ch.reply_seq)
    else $error("reply fields set on payload or disconnect");

  // A reply always acknowledges the other sequence.
  a_reply_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.reply_kind != RP_NONE
    |-> out_ch.reply_seq != out_ch.frame_seq)
    else $error("reply sequence not inverse of frame sequence");

endmodule

### sim/byte_stuffed_frame_receiver_tb.sv
module byte_stuffed_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfr_pkg::*;

  // No transfer on either channel for this many cycles means the block hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Spare cycles after the results drain, before a cfg write.
  localparam int DRAIN_CYCLES = 4;

  // Parser phases of the line decoder (mirror of the block's frame walk).
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_CTRL,
    PH_HDR_INFO,
    PH_HDR_DISC,
    PH_DATA,
    PH_DISC_END
  } rx_phase_t;

  logic clk;
  logic rst_n;

  bsfr_in_if  in_ch();
  bsfr_out_if out_ch();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  byte_stuffed_frame_receiver u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Line decoder model state: register copy plus frame parser.
  // ---------------------------------------------------------------------------
  cfg_t       cur_cfg;
  rx_phase_t  ph;
  logic       exp_seq;      // sequence the next good frame must carry
  logic       cur_seq;      // sequence of the frame being parsed
  logic [7:0] ctrl_seen;
  logic       esc_pend;     // escape byte seen, waiting for its code
  logic [7:0] held_byte;    // last destuffed byte, held back as the candidate check
  logic       held_ok;
  logic [7:0] run_xor;
  logic       esc_err;      // bad pair: rest of frame ignored, verdict is reject
  logic       payload_out;  // at least one payload byte left in this frame

  res_t       expected_results[$];
  int         err_count = 0;

  // Stimulus control
  logic [7:0] line_bytes[$];
  int         bytes_sent = 0;
  bit         idle_on = 1'b1;
  bit         line_open = 1'b0;  // last frame closed on a flag, block waits for address
  logic       gen_seq = 1'b0;    // stimulus guess of the expected sequence
  int         gap_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // One line byte through the decoder; returns 1 when the byte yields a result.
  function automatic bit decode_line_byte(input logic [7:0] b, output res_t r);
    logic [7:0] d;
    bit good;
    r = '0;
    case (ph)
      PH_ADDR: begin
        if (b == cur_cfg.addr) ph = PH_CTRL;
        else if (b != cur_cfg.flag) ph = PH_HUNT;
        return 1'b0;
      end
      PH_CTRL: begin
        // first match wins: info0, info1, disconnect, then flag
        if (b == cur_cfg.info0) begin
          cur_seq = 1'b0;
          ctrl_seen = b;
          ph = PH_HDR_INFO;
        end else if (b == cur_cfg.info1) begin
          cur_seq = 1'b1;
          ctrl_seen = b;
          ph = PH_HDR_INFO;
        end else if (b == cur_cfg.disc) begin
          ctrl_seen = b;
          ph = PH_HDR_DISC;
        end else if (b == cur_cfg.flag) begin
          ph = PH_ADDR;
        end else begin
          ph = PH_HUNT;
        end
        return 1'b0;
      end
      PH_HDR_INFO, PH_HDR_DISC: begin
        if (b == (cur_cfg.addr ^ ctrl_seen)) begin
          if (ph == PH_HDR_DISC) begin
            ph = PH_DISC_END;
          end else begin
            ph = PH_DATA;
            esc_pend = 1'b0;
            held_ok = 1'b0;
            held_byte = '0;
            run_xor = '0;
            esc_err = 1'b0;
            payload_out = 1'b0;
          end
        end else if (b == cur_cfg.flag) begin
          ph = PH_ADDR;
        end else begin
          ph = PH_HUNT;
        end
        return 1'b0;
      end
      PH_DISC_END: begin
        if (b == cur_cfg.flag) begin
          ph = PH_ADDR;
          r.result_kind = RK_DISC;
          return 1'b1;
        end
        ph = PH_HUNT;
        return 1'b0;
      end
      PH_DATA: begin
        if (b == cur_cfg.flag) begin
          // closing flag; it also opens the next frame
          good = !esc_err && !esc_pend && held_ok && payload_out && (run_xor == held_byte);
          ph = PH_ADDR;
          r.reply_seq = ~cur_seq;
          r.frame_seq = cur_seq;
          if (!good) begin
            r.result_kind = RK_REJECT;
            r.reply_kind = RP_REJ;
          end else if (cur_seq == exp_seq) begin
            exp_seq = ~exp_seq;
            r.result_kind = RK_ACCEPT;
            r.reply_kind = RP_RR;
          end else begin
            r.result_kind = RK_DUP;
            r.reply_kind = RP_RR;
          end
          return 1'b1;
        end
        if (esc_err) return 1'b0;
        if (esc_pend) begin
          esc_pend = 1'b0;
          if (b == cur_cfg.flag_code) d = cur_cfg.flag;
          else if (b == cur_cfg.esc_esc) d = cur_cfg.esc;
          else begin
            esc_err = 1'b1;
            return 1'b0;
          end
        end else if (b == cur_cfg.esc) begin
          esc_pend = 1'b1;
          return 1'b0;
        end else begin
          d = b;
        end
        if (held_ok) begin
          r.result_kind = RK_PAYLOAD;
          r.payload_byte = held_byte;
          run_xor ^= held_byte;
          payload_out = 1'b1;
          held_byte = d;
          return 1'b1;
        end
        held_byte = d;
        held_ok = 1'b1;
        return 1'b0;
      end
      default: begin
        ph = (b == cur_cfg.flag) ? PH_ADDR : PH_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each output transfer.
  // Samples pre-edge values at the rising edge.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin : line_monitor
    res_t pred;
    res_t got;
    res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (decode_line_byte(in_ch.rx_byte, pred)) expected_results.push_back(pred);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind  = out_ch.result_kind;
        got.payload_byte = out_ch.payload_byte;
        got.reply_kind   = out_ch.reply_kind;
        got.reply_seq    = out_ch.reply_seq;
        got.frame_seq    = out_ch.frame_seq;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0d byte 0x%0h",
                                    got.result_kind, got.payload_byte));
        end else begin
          want = expected_results.pop_front();
          if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind got %0d expected %0d",
                                      got.result_kind, want.result_kind));
          if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte got 0x%0h expected 0x%0h",
                                      got.payload_byte, want.payload_byte));
          if (got.reply_kind !== want.reply_kind)
            report_mismatch($sformatf("reply_kind got %0d expected %0d",
                                      got.reply_kind, want.reply_kind));
          if (got.reply_seq !== want.reply_seq)
            report_mismatch($sformatf("reply_seq got %0d expected %0d",
                                      got.reply_seq, want.reply_seq));
          if (got.frame_seq !== want.frame_seq)
            report_mismatch($sformatf("frame_seq got %0d expected %0d",
                                      got.frame_seq, want.frame_seq));
        end
      end
      // watchdog: any transfer on either channel counts as progress
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: random stall bursts, with the stall rate
  // re-picked among 0, 10 and 35 percent so some stretches never stall.
  // ---------------------------------------------------------------------------
  initial begin : result_backpressure
    int stall_left;
    int stall_pct;
    int tick;
    stall_left = 0;
    stall_pct = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tick % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      tick++;
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(1, 100) <= stall_pct) begin
        stall_left = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line side
  // ---------------------------------------------------------------------------

  // One byte transfer; valid stays high on return so back-to-back bytes
  // need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b);
    if (bytes_sent % 48 == 0) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 6;
        default: gap_pct = 25;
      endcase
    end
    if (idle_on && $urandom_range(1, 100) <= gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  // Payload/check byte with stuffing applied under the current codes.
  function automatic void push_stuffed(input logic [7:0] b);
    if (b == cur_cfg.flag) begin
      line_bytes.push_back(cur_cfg.esc);
      line_bytes.push_back(cur_cfg.flag_code);
    end else if (b == cur_cfg.esc) begin
      line_bytes.push_back(cur_cfg.esc);
      line_bytes.push_back(cur_cfg.esc_esc);
    end else begin
      line_bytes.push_back(b);
    end
  endfunction

  // Address, control and header check.
  function automatic void push_header(input logic [7:0] ctl);
    line_bytes.push_back(cur_cfg.addr);
    line_bytes.push_back(ctl);
    line_bytes.push_back(cur_cfg.addr ^ ctl);
  endfunction

  // Lower valid, let the monitor see the last transfer, let every expected
  // result drain, then a few spare cycles.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB writes: setup then access; register lands at psel&penable&pwrite&pready.
  // psel is left high between back-to-back writes and dropped by the caller.
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FLAG:     cur_cfg.flag = val;
      REG_ADDR:     cur_cfg.addr = val;
      REG_INFO0:    cur_cfg.info0 = val;
      REG_INFO1:    cur_cfg.info1 = val;
      REG_DISC:     cur_cfg.disc = val;
      REG_ESC:      cur_cfg.esc = val;
      REG_ESC_FLAG: cur_cfg.flag_code = val;
      REG_ESC_ESC:  cur_cfg.esc_esc = val;
      default: ;
    endcase
  endtask

  task automatic write_all_cfg(input cfg_t c);
    wait_idle();
    cfg_write(REG_FLAG, c.flag);
    cfg_write(REG_ADDR, c.addr);
    cfg_write(REG_INFO0, c.info0);
    cfg_write(REG_INFO1, c.info1);
    cfg_write(REG_DISC, c.disc);
    cfg_write(REG_ESC, c.esc);
    cfg_write(REG_ESC_FLAG, c.flag_code);
    cfg_write(REG_ESC_ESC, c.esc_esc);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // new codes may not match where the old frame left the parser
    line_open = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random frame: mostly well formed info frames with random content, plus
  // bad check, bad pair, escape before close, empty, disconnect, header faults
  // and line noise.
  // ---------------------------------------------------------------------------
  task automatic send_frame_random();
    int         kind;
    int         len;
    int         bad_at;
    logic       seq_pick;
    logic [7:0] ctl;
    logic [7:0] chk;
    logic [7:0] d;
    logic [7:0] bad;
    logic [7:0] body[$];
    kind = $urandom_range(0, 99);
    // closing flag doubles as opener; only re-send one now and then
    if (!line_open || $urandom_range(0, 3) == 0) line_bytes.push_back(cur_cfg.flag);
    line_open = 1'b1;
    if (kind < 67) begin
      seq_pick = ($urandom_range(0, 4) == 0) ? ~gen_seq : gen_seq;
      ctl = seq_pick ? cur_cfg.info1 : cur_cfg.info0;
      if (kind < 50 && seq_pick == gen_seq) gen_seq = ~gen_seq;
      if (kind >= 63) len = 0;
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(13, 40);
      else len = $urandom_range(1, 12);
      chk = '0;
      repeat (len) begin
        // lean on the codes so stuffing gets exercised
        case ($urandom_range(0, 11))
          0: d = cur_cfg.flag;
          1: d = cur_cfg.esc;
          2: d = cur_cfg.flag_code;
          3: d = cur_cfg.esc_esc;
          4: d = 8'h00;
          5: d = 8'hFF;
          default: d = 8'($urandom);
        endcase
        body.push_back(d);
        chk ^= d;
      end
      if (len == 0) chk = 8'($urandom);
      if (kind >= 50 && kind < 55) chk ^= 8'($urandom_range(1, 255));
      bad_at = (kind >= 55 && kind < 60) ? $urandom_range(0, len - 1) : -1;
      push_header(ctl);
      foreach (body[i]) begin
        if (i == bad_at) begin
          do bad = 8'($urandom);
          while (bad == cur_cfg.flag_code || bad == cur_cfg.esc_esc || bad == cur_cfg.flag);
          line_bytes.push_back(cur_cfg.esc);
          line_bytes.push_back(bad);
        end
        push_stuffed(body[i]);
      end
      // empty frame: either nothing at all or only a check byte
      if (len != 0 || $urandom_range(0, 1) == 1) push_stuffed(chk);
      if (kind >= 60 && kind < 63) line_bytes.push_back(cur_cfg.esc);
      line_bytes.push_back(cur_cfg.flag);
    end else if (kind < 75) begin
      push_header(cur_cfg.disc);
      if (kind < 72) begin
        line_bytes.push_back(cur_cfg.flag);
      end else begin
        line_bytes.push_back(8'($urandom));
        line_open = 1'b0;
      end
    end else if (kind < 87) begin
      case ($urandom_range(0, 4))
        0: begin
          line_bytes.push_back(8'($urandom));
          line_open = 1'b0;
        end
        1: begin
          line_bytes.push_back(cur_cfg.addr);
          line_bytes.push_back(8'($urandom));
          line_open = 1'b0;
        end
        2: begin
          line_bytes.push_back(cur_cfg.addr);
          line_bytes.push_back(cur_cfg.info0);
          line_bytes.push_back(8'($urandom));
          line_open = 1'b0;
        end
        3: begin
          // flag in control position: back to waiting for address
          line_bytes.push_back(cur_cfg.addr);
          line_bytes.push_back(cur_cfg.flag);
        end
        default: begin
          // flag where the header check belongs
          line_bytes.push_back(cur_cfg.addr);
          line_bytes.push_back(cur_cfg.info1);
          line_bytes.push_back(cur_cfg.flag);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom));
      line_open = 1'b0;
    end
    send_line();
  endtask

  task automatic send_random_frames(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) send_frame_random();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Good frame with stuffed flag, duplicate with stuffed escape and 0xFF,
  // then a disconnect; each closing flag opens the next frame.
  task automatic test_good_dup_disc();
    line_bytes.push_back(cur_cfg.flag);
    push_header(cur_cfg.info0);
    push_stuffed(cur_cfg.flag);
    push_stuffed(cur_cfg.flag);
    line_bytes.push_back(cur_cfg.flag);
    push_header(cur_cfg.info0);
    push_stuffed(cur_cfg.esc);
    push_stuffed(8'hFF);
    push_stuffed(cur_cfg.esc ^ 8'hFF);
    line_bytes.push_back(cur_cfg.flag);
    push_header(cur_cfg.disc);
    line_bytes.push_back(cur_cfg.flag);
    send_line();
    wait_idle();
  endtask

  // Bad escape pair, escape right before the closing flag, check-only frame.
  task automatic test_reject_cases();
    push_header(cur_cfg.info1);
    line_bytes.push_back(cur_cfg.esc);
    line_bytes.push_back(8'h00);
    line_bytes.push_back(cur_cfg.flag);
    push_header(cur_cfg.info1);
    line_bytes.push_back(cur_cfg.esc);
    line_bytes.push_back(cur_cfg.flag);
    push_header(cur_cfg.info1);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(cur_cfg.flag);
    send_line();
    line_open = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_default();
    send_random_frames(300);
  endtask

  task automatic test_low_codes();
    write_all_cfg('{flag: 8'h00, addr: 8'h01, info0: 8'h02, info1: 8'h03,
                    disc: 8'h04, esc: 8'h05, flag_code: 8'h06, esc_esc: 8'h07});
    send_random_frames(180);
  endtask

  task automatic test_high_codes();
    write_all_cfg('{flag: 8'hFF, addr: 8'hFE, info0: 8'hFD, info1: 8'hFC,
                    disc: 8'hFB, esc: 8'hFA, flag_code: 8'hF9, esc_esc: 8'hF8});
    send_random_frames(180);
  endtask

  // Equal codes: info1 shadowed by info0, disconnect shadows the flag in
  // the control slot.
  task automatic test_shared_codes();
    write_all_cfg('{flag: FLAG_RST, addr: ADDR_RST, info0: 8'h22, info1: 8'h22,
                    disc: FLAG_RST, esc: ESC_RST, flag_code: ESC_FLAG_RST,
                    esc_esc: ESC_ESC_RST});
    send_random_frames(120);
  endtask

  task automatic test_random_codes();
    cfg_t c;
    repeat (2) begin
      c = cfg_t'({$urandom, $urandom});
      write_all_cfg(c);
      send_random_frames(100);
    end
  endtask

  // Reset codes again, both sides at full rate.
  task automatic test_full_rate();
    write_all_cfg('{flag: FLAG_RST, addr: ADDR_RST, info0: INFO0_RST, info1: INFO1_RST,
                    disc: DISC_RST, esc: ESC_RST, flag_code: ESC_FLAG_RST,
                    esc_esc: ESC_ESC_RST});
    idle_on = 1'b0;
    send_random_frames(200);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_n         <= 1'b0;

    cur_cfg = '{flag: FLAG_RST, addr: ADDR_RST, info0: INFO0_RST, info1: INFO1_RST,
                disc: DISC_RST, esc: ESC_RST, flag_code: ESC_FLAG_RST,
                esc_esc: ESC_ESC_RST};
    ph          = PH_HUNT;
    exp_seq     = 1'b0;
    cur_seq     = 1'b0;
    ctrl_seen   = '0;
    esc_pend    = 1'b0;
    held_byte   = '0;
    held_ok     = 1'b0;
    run_xor     = '0;
    esc_err     = 1'b0;
    payload_out = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_good_dup_disc();
    test_reject_cases();
    test_random_default();
    test_low_codes();
    test_high_codes();
    test_shared_codes();
    test_random_codes();
    test_full_rate();

    wait_idle();
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
